>>> src/pics_pkg.sv
// Shared widths and fixed-point helpers for the inductor companion step block.
package pics_pkg;

	// Coefficient fraction bits (Q2.30)
	localparam int COEF_BITS = 30;
	// Divider operand widths
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 34;
	// Width of a rounded coefficient-times-signal result
	localparam int RND_W = 36;
	// Width used for sums ahead of saturation
	localparam int SUM_W = 38;
	// Accumulator width for a complex product
	localparam int ACC_W = 66;

	// Saturate to 32 bits; top bit of the result is the clip flag
	function automatic logic [32:0] sat32(input logic signed [SUM_W-1:0] x);
		logic [32:0] r;
		if (x[SUM_W-1:31] == '0 || x[SUM_W-1:31] == '1) begin
			r = {1'b0, x[31:0]};
		end else if (x[SUM_W-1]) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b1, 32'h7fff_ffff};
		end
		return r;
	endfunction

	// Shift right by the coefficient fraction with rounding half up
	function automatic logic signed [RND_W-1:0] rnd_coef(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] t;
		t = x + (ACC_W'(1) <<< (COEF_BITS - 1));
		return t[ACC_W-1:COEF_BITS];
	endfunction

endpackage

>>> src/pics_div.sv
// Restoring divider, one quotient bit a cycle, rounding half away from zero.
module pics_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pics_pkg::DIV_NUM_W-1:0] num,
	input  logic [pics_pkg::DIV_DEN_W-1:0] den,
	output logic                           done,
	output logic [pics_pkg::DIV_NUM_W-1:0] quot
);
	import pics_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_NUM_W-1:0] dvd_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   sh;
	logic [DIV_DEN_W+1:0] trial;

	// Trial subtract of the shifted remainder
	assign sh    = {rem_q, dvd_q[DIV_NUM_W-1]};
	assign trial = {1'b0, sh} - {2'b00, den_q};

	// Control: count the quotient bits and raise done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load rounded dividend, then shift in quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= num + DIV_NUM_W'(den >> 1);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DIV_DEN_W+1]) begin
				rem_q <= trial[DIV_DEN_W-1:0];
				dvd_q <= {dvd_q[DIV_NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[DIV_DEN_W-1:0];
				dvd_q <= {dvd_q[DIV_NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = dvd_q;

endmodule

>>> src/phasor_inductor_companion_step.sv
// Top level: dynamic-phasor trapezoidal inductor companion step with a shared multiplier.
//
//  channel   direction  handshake             payload
//  config    in/out     APB psel/penable      paddr, pwdata, prdata
//  input     in         in_valid / in_stall   cmd, node1_re/_im, node0_re/_im
//  result    out        out_valid / out_stall current_re/_im, source_re/_im, saturated
//
// A time step runs two complex products of four passes each through the one 33x32
// multiplier plus a drain step, a rounding step after each and one current update
// step. A restart runs six 64-bit divisions, one after another, in the bit-serial
// divider. One transaction at a time; in_stall is high until the result has been
// taken. Reset clears the configuration and companion state to zero.
module phasor_inductor_companion_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic signed [31:0] node1_re,
	input  logic signed [31:0] node1_im,
	input  logic signed [31:0] node0_re,
	input  logic signed [31:0] node0_im,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] current_re,
	output logic signed [31:0] current_im,
	output logic signed [31:0] source_re,
	output logic signed [31:0] source_im,
	output logic               saturated
);
	import pics_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_B2    = 10'b0000000010,
		ST_DCALC = 10'b0000000100,
		ST_PREP  = 10'b0000001000,
		ST_START = 10'b0000010000,
		ST_WAIT  = 10'b0000100000,
		ST_INIT  = 10'b0001000000,
		ST_MUL   = 10'b0010000000,
		ST_POST  = 10'b0100000000,
		ST_CUR   = 10'b1000000000
	} state_t;

	typedef enum logic [1:0] {
		PH_GV    = 2'd0,
		PH_FIRST = 2'd1,
		PH_LAST  = 2'd2
	} phase_t;

	// Register indexes
	localparam logic [2:0] REG_A    = 3'd0;
	localparam logic [2:0] REG_B    = 3'd1;
	localparam logic [2:0] REG_VRE  = 3'd2;
	localparam logic [2:0] REG_VIM  = 3'd3;
	localparam logic [2:0] REG_GND0 = 3'd4;
	localparam logic [2:0] REG_GND1 = 3'd5;

	// Division sequence
	localparam logic [2:0] IDX_GRE = 3'd0;
	localparam logic [2:0] IDX_AB  = 3'd1;
	localparam logic [2:0] IDX_FRE = 3'd2;
	localparam logic [2:0] IDX_FIM = 3'd3;
	localparam logic [2:0] IDX_QR  = 3'd4;
	localparam logic [2:0] IDX_QI  = 3'd5;

	localparam logic [32:0] COEF_ONE = 33'd1 << COEF_BITS;

	state_t state_q;
	phase_t phase_q;
	logic   out_q;
	logic   restart_q;
	logic   sat_q;
	logic [2:0] k_q;
	logic [2:0] idx_q;

	logic [30:0]        a_q, b_q;
	logic signed [31:0] ivre_q, ivim_q;
	logic               gnd0_q, gnd1_q;

	logic signed [32:0] g_re_q, g_im_q, f_re_q, f_im_q;
	logic signed [31:0] cur_re_q, cur_im_q, src_re_q, src_im_q;
	logic signed [31:0] v_re_q, v_im_q;
	logic signed [RND_W-1:0] gv_re_q, gv_im_q;
	logic signed [64:0] prod_q;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic [32:0]        b2_q;
	logic [DIV_DEN_W-1:0] d_q;
	logic [DIV_NUM_W-1:0] qr_q;

	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [64:0] prod;
	logic signed [32:0] c0, c1;
	logic signed [31:0] s0, s1;
	logic [32:0]        mag_vre, mag_vim, fdiff;
	logic [DIV_NUM_W-1:0] div_num, div_quot;
	logic [DIV_DEN_W-1:0] div_den;
	logic               div_start, div_done;
	logic signed [32:0] q33;
	logic signed [ACC_W-1:0] pext;
	logic signed [RND_W-1:0] rnd_re, rnd_im;
	logic [32:0]        r_clip, m_clip;
	logic [SUM_W-1:0]   i0_re, i0_im;
	logic [32:0]        sat_a, sat_b;
	logic signed [31:0] n1_re, n1_im, n0_re, n0_im;
	logic [63:0]        b2_full;
	logic               cfg_wr, in_acc;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign in_acc = in_valid && !in_stall;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			ivre_q <= '0;
			ivim_q <= '0;
			gnd0_q <= 1'b0;
			gnd1_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_A:    a_q    <= pwdata[30:0];
				REG_B:    b_q    <= pwdata[30:0];
				REG_VRE:  ivre_q <= pwdata;
				REG_VIM:  ivim_q <= pwdata;
				REG_GND0: gnd0_q <= pwdata[0];
				REG_GND1: gnd1_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		unique case (paddr[4:2])
			REG_A:    prdata = {1'b0, a_q};
			REG_B:    prdata = {1'b0, b_q};
			REG_VRE:  prdata = ivre_q;
			REG_VIM:  prdata = ivim_q;
			REG_GND0: prdata = {31'd0, gnd0_q};
			REG_GND1: prdata = {31'd0, gnd1_q};
			default:  prdata = '0;
		endcase
	end

	// Operand magnitudes and factor numerators
	assign mag_vre = v_re_q[31] ? (33'd0 - {v_re_q[31], v_re_q}) : {1'b0, v_re_q};
	assign mag_vim = v_im_q[31] ? (33'd0 - {v_im_q[31], v_im_q}) : {1'b0, v_im_q};
	assign fdiff   = (b2_q <= COEF_ONE) ? (COEF_ONE - b2_q) : (b2_q - COEF_ONE);

	// Select coefficient and signal for the complex product
	assign c0 = (phase_q == PH_GV) ? g_re_q : f_re_q;
	assign c1 = (phase_q == PH_GV) ? g_im_q : f_im_q;
	assign s0 = (phase_q == PH_GV) ? v_re_q : cur_re_q;
	assign s1 = (phase_q == PH_GV) ? v_im_q : cur_im_q;

	// Shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_B2: begin
				mul_a = {2'b00, b_q};
				mul_b = {1'b0, b_q};
			end
			ST_PREP: begin
				case (idx_q)
					IDX_AB: begin
						mul_a = {2'b00, a_q};
						mul_b = {1'b0, b_q};
					end
					IDX_QR: begin
						mul_a = mag_vim;
						mul_b = {1'b0, a_q};
					end
					IDX_QI: begin
						mul_a = mag_vre;
						mul_b = {1'b0, a_q};
					end
					default: ;
				endcase
			end
			ST_MUL: begin
				case (k_q)
					3'd0: begin
						mul_a = c0;
						mul_b = s0;
					end
					3'd1: begin
						mul_a = c1;
						mul_b = s1;
					end
					3'd2: begin
						mul_a = c0;
						mul_b = s1;
					end
					3'd3: begin
						mul_a = c1;
						mul_b = s0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= prod;
	end

	// Rounded square of b
	assign b2_full = (prod_q[63:0] + (64'd1 << (COEF_BITS - 1))) >> COEF_BITS;

	// Divider numerator and divisor per step of the sequence
	always_comb begin
		case (idx_q)
			IDX_GRE: div_num = {3'b000, a_q, 30'd0};
			IDX_FRE: div_num = {1'b0, fdiff, 30'd0};
			IDX_FIM: div_num = {2'b00, b_q, 31'd0};
			default: div_num = prod_q[DIV_NUM_W-1:0];
		endcase
		div_den = (idx_q < IDX_QR) ? d_q : {3'b000, b_q};
	end

	assign div_start = (state_q == ST_START);

	pics_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign q33 = div_quot[32:0];

	// Initial current from the clipped quotients
	assign r_clip = (qr_q > DIV_NUM_W'(64'h8000_0000)) ? 33'h1_0000_0000 : qr_q[32:0];
	assign m_clip = (div_quot > DIV_NUM_W'(64'h8000_0000)) ? 33'h1_0000_0000 : div_quot[32:0];
	assign i0_re  = v_im_q[31] ? (SUM_W'(0) - {5'd0, r_clip}) : {5'd0, r_clip};
	assign i0_im  = v_re_q[31] ? {5'd0, m_clip} : (SUM_W'(0) - {5'd0, m_clip});

	// Rounded product and step voltage difference
	assign pext   = {prod_q[64], prod_q};
	assign rnd_re = rnd_coef(acc_re_q);
	assign rnd_im = rnd_coef(acc_im_q);
	assign n1_re  = gnd1_q ? 32'sd0 : node1_re;
	assign n1_im  = gnd1_q ? 32'sd0 : node1_im;
	assign n0_re  = gnd0_q ? 32'sd0 : node0_re;
	assign n0_im  = gnd0_q ? 32'sd0 : node0_im;

	// Shared saturation inputs, chosen by state
	always_comb begin
		sat_a = sat32({{6{n1_re[31]}}, n1_re} - {{6{n0_re[31]}}, n0_re});
		sat_b = sat32({{6{n1_im[31]}}, n1_im} - {{6{n0_im[31]}}, n0_im});
		unique case (state_q)
			ST_INIT: begin
				sat_a = sat32(i0_re);
				sat_b = sat32(i0_im);
			end
			ST_POST: begin
				sat_a = sat32({{2{gv_re_q[RND_W-1]}}, gv_re_q} +
					{{2{rnd_re[RND_W-1]}}, rnd_re});
				sat_b = sat32({{2{gv_im_q[RND_W-1]}}, gv_im_q} +
					{{2{rnd_im[RND_W-1]}}, rnd_im});
			end
			ST_CUR: begin
				sat_a = sat32({{2{gv_re_q[RND_W-1]}}, gv_re_q} +
					{{6{src_re_q[31]}}, src_re_q});
				sat_b = sat32({{2{gv_im_q[RND_W-1]}}, gv_im_q} +
					{{6{src_im_q[31]}}, src_im_q});
			end
			default: ;
		endcase
	end

	// Sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_GV;
			out_q     <= 1'b0;
			restart_q <= 1'b0;
			sat_q     <= 1'b0;
			k_q       <= '0;
			idx_q     <= '0;
			g_re_q    <= '0;
			g_im_q    <= '0;
			f_re_q    <= '0;
			f_im_q    <= '0;
			cur_re_q  <= '0;
			cur_im_q  <= '0;
			src_re_q  <= '0;
			src_im_q  <= '0;
			v_re_q    <= '0;
			v_im_q    <= '0;
			gv_re_q   <= '0;
			gv_im_q   <= '0;
			acc_re_q  <= '0;
			acc_im_q  <= '0;
			b2_q      <= '0;
			d_q       <= '0;
			qr_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// Drop the result once taken, then take the next transaction
					if (out_q && !out_stall) begin
						out_q <= 1'b0;
					end
					if (in_acc) begin
						if (cmd) begin
							v_re_q    <= sat_a[31:0];
							v_im_q    <= sat_b[31:0];
							sat_q     <= sat_a[32] | sat_b[32];
							restart_q <= 1'b0;
							phase_q   <= PH_GV;
							k_q       <= '0;
							state_q   <= ST_MUL;
						end else begin
							v_re_q    <= ivre_q;
							v_im_q    <= ivim_q;
							sat_q     <= 1'b0;
							restart_q <= 1'b1;
							state_q   <= ST_B2;
						end
					end
				end
				ST_B2: begin
					state_q <= ST_DCALC;
				end
				ST_DCALC: begin
					b2_q    <= b2_full[32:0];
					d_q     <= {1'b0, COEF_ONE} + {1'b0, b2_full[32:0]};
					idx_q   <= IDX_GRE;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					// Store each quotient and advance the division list
					if (div_done) begin
						case (idx_q)
							IDX_GRE: g_re_q <= q33;
							IDX_AB:  g_im_q <= -q33;
							IDX_FRE: f_re_q <= (b2_q <= COEF_ONE) ? q33 : -q33;
							IDX_FIM: f_im_q <= -q33;
							IDX_QR:  qr_q   <= div_quot;
							default: ;
						endcase
						if (idx_q == IDX_QI) begin
							state_q <= ST_INIT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_PREP;
						end
					end
				end
				ST_INIT: begin
					if (b_q == '0) begin
						cur_re_q <= '0;
						cur_im_q <= '0;
					end else begin
						cur_re_q <= sat_a[31:0];
						cur_im_q <= sat_b[31:0];
						sat_q    <= sat_q | sat_a[32] | sat_b[32];
					end
					phase_q <= PH_GV;
					k_q     <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// Accumulate the product issued in the previous cycle
					k_q <= k_q + 1'b1;
					case (k_q)
						3'd1: acc_re_q <= pext;
						3'd2: acc_re_q <= acc_re_q - pext;
						3'd3: acc_im_q <= pext;
						3'd4: acc_im_q <= acc_im_q + pext;
						default: ;
					endcase
					if (k_q == 3'd4) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					k_q <= '0;
					case (phase_q)
						PH_GV: begin
							gv_re_q <= rnd_re;
							gv_im_q <= rnd_im;
							if (restart_q) begin
								phase_q <= PH_FIRST;
								state_q <= ST_MUL;
							end else begin
								state_q <= ST_CUR;
							end
						end
						PH_FIRST: begin
							src_re_q  <= sat_a[31:0];
							src_im_q  <= sat_b[31:0];
							sat_q     <= sat_q | sat_a[32] | sat_b[32];
							restart_q <= 1'b0;
							state_q   <= ST_CUR;
						end
						default: begin
							src_re_q <= sat_a[31:0];
							src_im_q <= sat_b[31:0];
							sat_q    <= sat_q | sat_a[32] | sat_b[32];
							out_q    <= 1'b1;
							state_q  <= ST_IDLE;
						end
					endcase
				end
				ST_CUR: begin
					// Advance the current: i = G*v + source
					cur_re_q <= sat_a[31:0];
					cur_im_q <= sat_b[31:0];
					sat_q    <= sat_q | sat_a[32] | sat_b[32];
					phase_q  <= PH_LAST;
					k_q      <= '0;
					state_q  <= ST_MUL;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall   = (state_q != ST_IDLE) || (out_q && out_stall);
	assign out_valid  = out_q;
	assign current_re = cur_re_q;
	assign current_im = cur_im_q;
	assign source_re  = src_re_q;
	assign source_im  = src_im_q;
	assign saturated  = sat_q;

`ifndef NO_ASSERTIONS
	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input taken while result pending");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("block not busy after accepting a transaction");
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_WAIT)
		else $error("divider finished outside the wait step");
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_POST)
		else $error("result raised without finishing the update");
`endif

endmodule

>>> tb/sv/phasor_inductor_companion_checker.sv
// Checker for the inductor companion step block: predicts each result and compares it.
`timescale 1ns / 100ps

module phasor_inductor_companion_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               cmd,
	input  logic signed [31:0] node1_re,
	input  logic signed [31:0] node1_im,
	input  logic signed [31:0] node0_re,
	input  logic signed [31:0] node0_im,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] current_re,
	input  logic signed [31:0] current_im,
	input  logic signed [31:0] source_re,
	input  logic signed [31:0] source_im,
	input  logic               saturated,
	output int                 errors,
	output int                 pending
);

	typedef logic signed [79:0] wide_t;

	typedef struct packed {
		logic [31:0] cur_re;
		logic [31:0] cur_im;
		logic [31:0] src_re;
		logic [31:0] src_im;
		logic        sat;
	} companion_result_t;

	localparam wide_t ONE_Q30 = wide_t'(1) <<< 30;
	localparam wide_t HALF_Q30 = wide_t'(1) <<< 29;
	localparam wide_t MAX32 = wide_t'(32'sh7fff_ffff);
	localparam wide_t MIN32 = -(wide_t'(1) <<< 31);

	localparam logic [2:0] IDX_A = 3'd0;
	localparam logic [2:0] IDX_B = 3'd1;
	localparam logic [2:0] IDX_VRE = 3'd2;
	localparam logic [2:0] IDX_VIM = 3'd3;
	localparam logic [2:0] IDX_GND0 = 3'd4;
	localparam logic [2:0] IDX_GND1 = 3'd5;

	// Shadow registers and companion state
	wide_t coef_a, coef_b, volt_re, volt_im;
	logic  gnd0, gnd1;
	wide_t g_re, g_im, f_re, f_im, cur_re, cur_im, src_re, src_im;

	companion_result_t expected_q[$];

	assign pending = expected_q.size();

	function automatic wide_t clip32(input wide_t x, inout logic flag);
		if (x > MAX32) begin
			flag = 1'b1;
			return MAX32;
		end
		if (x < MIN32) begin
			flag = 1'b1;
			return MIN32;
		end
		return x;
	endfunction

	function automatic wide_t div_round(input wide_t num, input wide_t den);
		return (num + den / 2) / den;
	endfunction

	function automatic wide_t shr_q30(input wide_t x);
		return (x + HALF_Q30) >>> 30;
	endfunction

	// Coefficient times signal, back on the signal scale
	task automatic coef_mul(input wide_t c0, c1, s0, s1, output wide_t r0, r1);
		r0 = shr_q30(c0 * s0 - c1 * s1);
		r1 = shr_q30(c0 * s1 + c1 * s0);
	endtask

	// One companion update: current from source, then the next source
	task automatic advance_branch(input wide_t v0, v1, s0, s1, inout logic flag);
		wide_t gv0, gv1, fi0, fi1;
		coef_mul(g_re, g_im, v0, v1, gv0, gv1);
		cur_re = clip32(gv0 + s0, flag);
		cur_im = clip32(gv1 + s1, flag);
		coef_mul(f_re, f_im, cur_re, cur_im, fi0, fi1);
		src_re = clip32(gv0 + fi0, flag);
		src_im = clip32(gv1 + fi1, flag);
	endtask

	task automatic restart_branch(inout logic flag);
		wide_t b2, d, i0re, i0im, mr, mi, qr, qi, gv0, gv1, fi0, fi1, s0, s1;
		b2 = (coef_b * coef_b + HALF_Q30) >>> 30;
		d = ONE_Q30 + b2;
		g_re = div_round(coef_a <<< 30, d);
		g_im = -div_round(coef_a * coef_b, d);
		if (b2 <= ONE_Q30) f_re = div_round((ONE_Q30 - b2) <<< 30, d);
		else f_re = -div_round((b2 - ONE_Q30) <<< 30, d);
		f_im = -div_round((2 * coef_b) <<< 30, d);
		i0re = 0;
		i0im = 0;
		if (coef_b != 0) begin
			mr = volt_im < 0 ? -volt_im : volt_im;
			mi = volt_re < 0 ? -volt_re : volt_re;
			qr = div_round(mr * coef_a, coef_b);
			qi = div_round(mi * coef_a, coef_b);
			if (qr > -MIN32) qr = -MIN32;
			if (qi > -MIN32) qi = -MIN32;
			i0re = clip32(volt_im < 0 ? -qr : qr, flag);
			i0im = clip32(volt_re < 0 ? qi : -qi, flag);
		end
		coef_mul(g_re, g_im, volt_re, volt_im, gv0, gv1);
		coef_mul(f_re, f_im, i0re, i0im, fi0, fi1);
		s0 = clip32(gv0 + fi0, flag);
		s1 = clip32(gv1 + fi1, flag);
		advance_branch(volt_re, volt_im, s0, s1, flag);
	endtask

	task automatic predict_transaction();
		logic flag;
		wide_t v0, v1;
		companion_result_t r;
		flag = 1'b0;
		if (cmd == 1'b0) begin
			restart_branch(flag);
		end else begin
			v0 = 0;
			v1 = 0;
			if (!gnd1) begin
				v0 = wide_t'(node1_re);
				v1 = wide_t'(node1_im);
			end
			if (!gnd0) begin
				v0 = v0 - wide_t'(node0_re);
				v1 = v1 - wide_t'(node0_im);
			end
			v0 = clip32(v0, flag);
			v1 = clip32(v1, flag);
			advance_branch(v0, v1, src_re, src_im, flag);
		end
		r.cur_re = cur_re[31:0];
		r.cur_im = cur_im[31:0];
		r.src_re = src_re[31:0];
		r.src_im = src_im[31:0];
		r.sat = flag;
		expected_q = {expected_q, r};
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp_v, act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
			errors++;
		end
	endtask

	// Watch the register port, the input and the result channels
	always @(posedge clk or negedge arst_n) begin
		companion_result_t e;
		if (!arst_n) begin
			coef_a = 0; coef_b = 0; volt_re = 0; volt_im = 0;
			gnd0 = 1'b0; gnd1 = 1'b0;
			g_re = 0; g_im = 0; f_re = 0; f_im = 0;
			cur_re = 0; cur_im = 0; src_re = 0; src_im = 0;
			errors = 0;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					IDX_A: coef_a = wide_t'(pwdata[30:0]);
					IDX_B: coef_b = wide_t'(pwdata[30:0]);
					IDX_VRE: volt_re = wide_t'($signed(pwdata));
					IDX_VIM: volt_im = wide_t'($signed(pwdata));
					IDX_GND0: gnd0 = pwdata[0];
					IDX_GND1: gnd1 = pwdata[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result transaction with no expectation waiting");
					errors++;
				end else begin
					e = expected_q.pop_front();
					compare_field("current_re", e.cur_re, current_re);
					compare_field("current_im", e.cur_im, current_im);
					compare_field("source_re", e.src_re, source_re);
					compare_field("source_im", e.src_im, source_im);
					compare_field("saturated", 32'(e.sat), 32'(saturated));
				end
			end
			if (in_valid && !in_stall) predict_transaction();
		end
	end

endmodule

>>> tb/sv/tb_phasor_inductor_companion_step.sv
// Testbench top for the inductor companion step block: stimulus, register writes and verdict.
`timescale 1ns / 100ps

module tb_phasor_inductor_companion_step;

	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_STEP = 1'b1;
	localparam logic [4:0] ADDR_A = 5'd0;
	localparam logic [4:0] ADDR_B = 5'd4;
	localparam logic [4:0] ADDR_VRE = 5'd8;
	localparam logic [4:0] ADDR_VIM = 5'd12;
	localparam logic [4:0] ADDR_GND0 = 5'd16;
	localparam logic [4:0] ADDR_GND1 = 5'd20;
	localparam logic [4:0] ADDR_NONE = 5'd24;
	localparam logic [31:0] COEF_MAX = 32'h7fff_ffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = CMD_STEP;
	logic signed [31:0] node1_re = '0, node1_im = '0, node0_re = '0, node0_im = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] current_re, current_im, source_re, source_im;
	logic saturated;
	int errors, pending;
	logic calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	phasor_inductor_companion_step dut (.*);

	phasor_inductor_companion_checker checker_i (.*);

	// Stall the result side at random, except in a calm stretch
	always @(posedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 21);

	function automatic logic [31:0] pick_signal();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(2000)) - 1000);
			3: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return COEF_MAX;
			2: return $urandom_range(1 << 20);
			3: return $urandom_range(1 << 28);
			default: return $urandom_range(COEF_MAX);
		endcase
	endfunction

	task automatic write_reg(input logic [4:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drain outstanding results, then load one full register setting
	task automatic load_setting(input logic [31:0] a, b, vre, vim, input logic g0, g1);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		write_reg(ADDR_A, a);
		write_reg(ADDR_B, b);
		write_reg(ADDR_VRE, vre);
		write_reg(ADDR_VIM, vim);
		write_reg(ADDR_GND0, {31'd0, g0});
		write_reg(ADDR_GND1, {31'd0, g1});
	endtask

	// Offer one transaction and hold it until accepted
	task automatic send_item(input logic c, input logic [31:0] n1r, n1i, n0r, n0i);
		if (!calm && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		node1_re <= n1r;
		node1_im <= n1i;
		node0_re <= n0r;
		node0_im <= n0i;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_step();
		send_item(CMD_STEP, pick_signal(), pick_signal(), pick_signal(), pick_signal());
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a restart and a step at the reset setting
		send_item(CMD_RESTART, '1, '1, '1, '1);
		send_item(CMD_STEP, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		drop_valid();

		// Typical coefficients, both terminals live
		load_setting(32'h0400_0000, 32'h0100_0000, 32'h0064_0000, 32'hffce_0000, 1'b0, 1'b0);
		write_reg(ADDR_NONE, 32'hffff_ffff);
		send_item(CMD_RESTART, '0, '0, '0, '0);
		send_item(CMD_STEP, 32'h0064_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_item(CMD_STEP, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		send_item(CMD_STEP, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(CMD_STEP, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'hffff_ffff);
		drop_valid();

		// Zero b: no initial current
		load_setting(32'h2000_0000, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0);
		send_item(CMD_RESTART, '0, '0, '0, '0);
		send_item(CMD_STEP, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		drop_valid();

		// Huge a over tiny b: initial current clips
		load_setting(COEF_MAX, 32'd1, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b1);
		send_item(CMD_RESTART, '0, '0, '0, '0);
		send_item(CMD_STEP, 32'h1234_5678, 32'h8765_4321, 32'h0001_0000, 32'hfff0_0000);
		drop_valid();

		// Both coefficients at the top, both terminals grounded
		load_setting(COEF_MAX, COEF_MAX, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1);
		send_item(CMD_RESTART, '0, '0, '0, '0);
		send_item(CMD_STEP, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(CMD_RESTART, '0, '0, '0, '0);
		drop_valid();

		// Random phases: a setting, a restart, then mostly steps
		n = 0;
		while (n < 1300) begin
			load_setting(pick_coef(), pick_coef(), pick_signal(), pick_signal(),
				$urandom_range(99) < 20, $urandom_range(99) < 20);
			calm <= ($urandom_range(9) == 0);
			send_item(CMD_RESTART, pick_signal(), pick_signal(), pick_signal(), pick_signal());
			n++;
			repeat ($urandom_range(60, 140)) begin
				if ($urandom_range(99) < 4)
					send_item(CMD_RESTART, $urandom, $urandom, $urandom, $urandom);
				else
					send_step();
				n++;
			end
			drop_valid();
			calm <= 1'b0;
		end

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Bound the run
	initial begin
		#40ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
